FILE: rtl/assert_macros.svh
// Assertion macros shared by the scaler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: rtl/bis_pkg.sv
// Types, constants and codes shared by the bilinear scaler modules.
`timescale 1ns / 1ps
package bis_pkg;

  localparam int DEF_MAX_SRC_WIDTH  = 512;
  localparam int DEF_MAX_SRC_HEIGHT = 512;
  localparam int DEF_MAX_DST_DIM    = 4096;

  localparam int CoordW = 10;  // width of a source coordinate (set by the size registers)
  localparam int DstW   = 12;  // width of a destination coordinate
  localparam int StepW  = 24;  // unsigned Q8.16 step
  localparam int PixW   = 24;  // three 8-bit channels
  localparam int WeightW = 17; // product of two 9-bit weights, at most 65536

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef enum logic {
    MODE_GREY   = 1'b0,
    MODE_COLOUR = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_STEP_X     = 3'd2,
    REG_STEP_Y     = 3'd3,
    REG_COLOR_MODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    func_t       func;
    logic [8:0]  src_col;
    logic [8:0]  src_row;
    logic [7:0]  pix_c0;
    logic [7:0]  pix_c1;
    logic [7:0]  pix_c2;
    logic [11:0] dst_col;
    logic [11:0] dst_row;
  } item_t;

  typedef struct packed {
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
  } result_t;

  typedef struct packed {
    logic [CoordW-1:0] source_width;
    logic [CoordW-1:0] source_height;
    logic [StepW-1:0]  step_x;
    logic [StepW-1:0]  step_y;
    mode_t             color_mode;
  } cfg_t;

  // Command from the coordinate mapper to the pixel store.
  typedef struct packed {
    func_t             func;
    logic [CoordW-1:0] col_lo;
    logic [CoordW-1:0] col_hi;
    logic [CoordW-1:0] row_lo;
    logic [CoordW-1:0] row_hi;
    logic [7:0]        fx;
    logic [7:0]        fy;
    logic [PixW-1:0]   pix;
  } op_t;

  // Tag that travels with each pixel read towards the blender.
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [WeightW-1:0] weight;
  } tag_t;

endpackage

FILE: rtl/bis_map.sv
// Input stage and coordinate mapper: source position, clamp and fractions.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bis_map #(
  parameter int MAX_SRC_WIDTH  = bis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = bis_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_DST_DIM    = bis_pkg::DEF_MAX_DST_DIM
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bis_pkg::item_t cmd,
  input  bis_pkg::cfg_t  cfg,
  output bis_pkg::op_t   op,
  output logic           op_valid,
  input  logic           op_ready
);
  import bis_pkg::*;

  localparam int DstLast = (MAX_DST_DIM - 1 < (1 << DstW) - 1) ?
                           MAX_DST_DIM - 1 : (1 << DstW) - 1;
  localparam int ProdW = DstW + StepW;
  localparam int LimW  = CoordW + 16;

  // Last usable index of an axis, after the size register is brought into range.
  function automatic logic [CoordW-1:0] dim_last(logic [CoordW-1:0] v, int maxv);
    logic [CoordW-1:0] r;
    if (v == '0) r = '0;
    else if (int'(v) > maxv) r = CoordW'(maxv - 1);
    else r = v - CoordW'(1);
    return r;
  endfunction

  logic              v1;
  func_t             s1_func;
  logic              s1_ldok;
  logic [CoordW-1:0] s1_col;
  logic [CoordW-1:0] s1_row;
  logic [PixW-1:0]   s1_pix;
  logic [ProdW-1:0]  s1_sx;
  logic [ProdW-1:0]  s1_sy;

  logic [DstW-1:0]   dc;
  logic [DstW-1:0]   dr;
  logic              accept;
  logic              s2_load;
  logic [LimW-1:0]   limx;
  logic [LimW-1:0]   limy;
  logic [LimW-1:0]   sxc;
  logic [LimW-1:0]   syc;
  op_t               op_next;

  assign s2_load = !op_valid || op_ready;
  assign busy    = v1 && !s2_load;
  assign accept  = start && !busy;

  assign dc = (int'(cmd.dst_col) > DstLast) ? DstW'(DstLast) : cmd.dst_col;
  assign dr = (int'(cmd.dst_row) > DstLast) ? DstW'(DstLast) : cmd.dst_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (s2_load) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func <= cmd.func;
      s1_ldok <= (int'(cmd.src_col) < MAX_SRC_WIDTH) && (int'(cmd.src_row) < MAX_SRC_HEIGHT);
      s1_col  <= CoordW'(cmd.src_col);
      s1_row  <= CoordW'(cmd.src_row);
      s1_pix  <= {cmd.pix_c2, cmd.pix_c1, cmd.pix_c0};
      s1_sx   <= ProdW'(dc) * ProdW'(cfg.step_x);
      s1_sy   <= ProdW'(dr) * ProdW'(cfg.step_y);
    end
  end

  // Clamp to the far edge of the source image, then split index and fraction.
  always_comb begin
    limx = {dim_last(cfg.source_width, MAX_SRC_WIDTH), 16'h0000};
    limy = {dim_last(cfg.source_height, MAX_SRC_HEIGHT), 16'h0000};
    sxc  = (s1_sx > ProdW'(limx)) ? limx : s1_sx[LimW-1:0];
    syc  = (s1_sy > ProdW'(limy)) ? limy : s1_sy[LimW-1:0];
    op_next.func   = s1_func;
    op_next.pix    = s1_pix;
    op_next.fx     = sxc[15:8];
    op_next.fy     = syc[15:8];
    op_next.col_lo = sxc[LimW-1:16];
    op_next.row_lo = syc[LimW-1:16];
    op_next.col_hi = sxc[LimW-1:16] + CoordW'(|sxc[15:0]);
    op_next.row_hi = syc[LimW-1:16] + CoordW'(|syc[15:0]);
    if (s1_func == FUNC_LOAD) begin
      op_next.col_lo = s1_col;
      op_next.row_lo = s1_row;
    end
  end

  // Drop loads that fall outside the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (s2_load) begin
      op_valid <= v1 && (s1_func == FUNC_SAMPLE || s1_ldok);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && v1) begin
      op <= op_next;
    end
  end

  `ASSERT_IMPLIES(a_busy_needs_item, clk, rst, busy, v1 && op_valid)

endmodule

FILE: rtl/bis_store.sv
// Pixel store: single-port memory and the four-read sequencer for samples.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bis_store #(
  parameter int MAX_SRC_WIDTH  = bis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = bis_pkg::DEF_MAX_SRC_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bis_pkg::op_t             op_in,
  input  logic                     op_in_valid,
  output logic                     op_ready,
  output logic [bis_pkg::PixW-1:0] rdata,
  output bis_pkg::tag_t            tag
);
  import bis_pkg::*;

  localparam int CW    = $clog2(MAX_SRC_WIDTH);
  localparam int RW    = $clog2(MAX_SRC_HEIGHT);
  localparam int AW    = CW + RW;
  localparam int Depth = MAX_SRC_HEIGHT * (2 ** CW);
  localparam logic [1:0] LastStep = 2'd3;

  logic [PixW-1:0] mem [Depth];

  op_t               cur;
  logic              cur_valid;
  logic [1:0]        step;
  logic              cur_last;
  logic              we;
  logic              re;
  logic [CoordW-1:0] col;
  logic [CoordW-1:0] row;
  logic [8:0]        wx;
  logic [8:0]        wy;
  logic [AW-1:0]     addr;

  assign cur_last = (cur.func == FUNC_LOAD) || (step == LastStep);
  assign op_ready = !cur_valid || cur_last;
  assign we       = cur_valid && (cur.func == FUNC_LOAD);
  assign re       = cur_valid && (cur.func == FUNC_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (op_ready) begin
      cur_valid <= op_in_valid;
      step      <= '0;
    end else begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && op_in_valid) begin
      cur <= op_in;
    end
  end

  // Neighbour order: top left, top right, bottom left, bottom right.
  always_comb begin
    case (step)
      2'd0: begin
        col = cur.col_lo;
        row = cur.row_lo;
        wx  = 9'd256 - {1'b0, cur.fx};
        wy  = 9'd256 - {1'b0, cur.fy};
      end
      2'd1: begin
        col = cur.col_hi;
        row = cur.row_lo;
        wx  = {1'b0, cur.fx};
        wy  = 9'd256 - {1'b0, cur.fy};
      end
      2'd2: begin
        col = cur.col_lo;
        row = cur.row_hi;
        wx  = 9'd256 - {1'b0, cur.fx};
        wy  = {1'b0, cur.fy};
      end
      default: begin
        col = cur.col_hi;
        row = cur.row_hi;
        wx  = {1'b0, cur.fx};
        wy  = {1'b0, cur.fy};
      end
    endcase
    addr = {RW'(row), CW'(col)};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= cur.pix;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= re;
    end
  end

  always_ff @(posedge clk) begin
    tag.first  <= (step == 2'd0);
    tag.last   <= (step == LastStep);
    tag.weight <= WeightW'(wy) * WeightW'(wx);
  end

  `ASSERT_IMPLIES(a_first_not_last, clk, rst, tag.valid && tag.first, !tag.last)
  `ASSERT_NEXT(a_reads_contiguous, clk, rst, tag.valid && tag.first, tag.valid && !tag.first)

endmodule

FILE: rtl/bis_blend.sv
// Blender: weighted sum of the four neighbours per channel, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bis_blend (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [bis_pkg::PixW-1:0] rdata,
  input  bis_pkg::tag_t            tag,
  input  bis_pkg::mode_t           color_mode,
  output logic                     done,
  output bis_pkg::result_t         result
);
  import bis_pkg::*;

  localparam int AccW = 24;

  logic [AccW-1:0] acc      [3];
  logic [AccW-1:0] prod     [3];
  logic [AccW-1:0] acc_next [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]     = AccW'(tag.weight) * AccW'(rdata[8*ch +: 8]);
      acc_next[ch] = (tag.first ? '0 : acc[ch]) + prod[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc[ch] <= acc_next[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag.valid && tag.last;
    end
  end

  // Truncate: keep the integer part of each weighted sum.
  always_ff @(posedge clk) begin
    if (tag.valid && tag.last) begin
      result.out_c0 <= acc_next[0][AccW-1:16];
      result.out_c1 <= (color_mode == MODE_COLOUR) ? acc_next[1][AccW-1:16] : 8'h00;
      result.out_c2 <= (color_mode == MODE_COLOUR) ? acc_next[2][AccW-1:16] : 8'h00;
    end
  end

  `ASSERT_NEXT(a_done_after_last, clk, rst, tag.valid && tag.last, done)

endmodule

FILE: rtl/bilinear_image_scaler.sv
// Bilinear image scaler top level: register port, mapper, pixel store and blender.
`timescale 1ns / 1ps
// Use:
//   Items enter on start while busy is low; cmd.func picks a load (write one
//   source pixel) or a sample (interpolate one destination pixel).
//   Each sample gives one result on result, marked by done for one cycle.
//   Loads give no result.
//   A sample's result passes the mapper's input stage, the op register,
//   the store's current op, the memory read data and tag, and the result
//   register. A sample's four neighbour reads and a load's write each
//   hold the single port of the pixel memory, and the store takes no new
//   item until the last is through. busy rises when the two input stages
//   are full. Items leave in the order in which they were accepted.
//   Registers are written over the APB port (psel, penable, pwrite high) by
//   the user only while the block is idle (not enforced); pready is always high.
//   Reset (rst, synchronous) empties the pipeline and loads the register
//   reset values; the pixel memory keeps its contents and needs no clearing.
//   The receiver cannot stall; done lasts exactly one cycle, result up to the next.
module bilinear_image_scaler #(
  parameter int MAX_SRC_WIDTH  = bis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = bis_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int MAX_DST_DIM    = bis_pkg::DEF_MAX_DST_DIM
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bis_pkg::item_t   cmd,
  output logic             done,
  output bis_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bis_pkg::*;

  cfg_t            cfg;
  op_t             op;
  logic            op_valid;
  logic            op_ready;
  logic [PixW-1:0] rdata;
  tag_t            tag;
  logic            wr_en;
  reg_idx_t        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= 10'd512;
      cfg.source_height <= 10'd512;
      cfg.step_x        <= 24'd65536;
      cfg.step_y        <= 24'd65536;
      cfg.color_mode    <= MODE_GREY;
    end else if (wr_en) begin
      case (idx)
        REG_SRC_WIDTH:  cfg.source_width  <= pwdata[CoordW-1:0];
        REG_SRC_HEIGHT: cfg.source_height <= pwdata[CoordW-1:0];
        REG_STEP_X:     cfg.step_x        <= pwdata[StepW-1:0];
        REG_STEP_Y:     cfg.step_y        <= pwdata[StepW-1:0];
        REG_COLOR_MODE: cfg.color_mode    <= mode_t'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_WIDTH:  prdata = 32'(cfg.source_width);
      REG_SRC_HEIGHT: prdata = 32'(cfg.source_height);
      REG_STEP_X:     prdata = 32'(cfg.step_x);
      REG_STEP_Y:     prdata = 32'(cfg.step_y);
      REG_COLOR_MODE: prdata = 32'(cfg.color_mode);
      default:        prdata = 32'h0;
    endcase
  end

  bis_map #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .MAX_DST_DIM   (MAX_DST_DIM)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .cfg     (cfg),
    .op      (op),
    .op_valid(op_valid),
    .op_ready(op_ready)
  );

  bis_store #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .op_in      (op),
    .op_in_valid(op_valid),
    .op_ready   (op_ready),
    .rdata      (rdata),
    .tag        (tag)
  );

  bis_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .rdata     (rdata),
    .tag       (tag),
    .color_mode(cfg.color_mode),
    .done      (done),
    .result    (result)
  );

endmodule
